// ===== hdl/raa_pkg.sv =====
// shared types and constants for the running average with alerts block
`default_nettype none

package raa_pkg;

    localparam int AVG_W      = 32;
    localparam int CNT_W      = 32;
    localparam int WIN_W      = 16;
    localparam int EN_W       = 3;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [WIN_W-1:0]        WINDOW_RESET = 16'd10;
    localparam logic signed [AVG_W-1:0] AVG_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [AVG_W-1:0] AVG_MIN      = -32'sh7FFF_FFFF - 32'sd1;

    // alert enable bit positions
    localparam int EN_CHG = 0;
    localparam int EN_LOW = 1;
    localparam int EN_UP  = 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WINDOW    = 3'd0,
        REG_START_CNT = 3'd1,
        REG_START_AVG = 3'd2,
        REG_LOWER     = 3'd3,
        REG_UPPER     = 3'd4,
        REG_ENABLES   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [WIN_W-1:0]        window_size;
        logic [CNT_W-1:0]        start_count;
        logic signed [AVG_W-1:0] start_average;
        logic signed [AVG_W-1:0] lower_threshold;
        logic signed [AVG_W-1:0] upper_threshold;
        logic [EN_W-1:0]         alert_enables;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SUM,
        ST_ALERT,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/raa_regs.sv =====
// apb configuration register file
`default_nettype none

module raa_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [raa_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [raa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [raa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output raa_pkg::t_cfg                         o_cfg
);
    import raa_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_size     <= WINDOW_RESET;
            r_cfg.start_count     <= '0;
            r_cfg.start_average   <= '0;
            r_cfg.lower_threshold <= '0;
            r_cfg.upper_threshold <= '0;
            r_cfg.alert_enables   <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WINDOW:    r_cfg.window_size     <= pwdata[WIN_W-1:0];
                REG_START_CNT: r_cfg.start_count     <= pwdata[CNT_W-1:0];
                REG_START_AVG: r_cfg.start_average   <= signed'(pwdata[AVG_W-1:0]);
                REG_LOWER:     r_cfg.lower_threshold <= signed'(pwdata[AVG_W-1:0]);
                REG_UPPER:     r_cfg.upper_threshold <= signed'(pwdata[AVG_W-1:0]);
                REG_ENABLES:   r_cfg.alert_enables   <= pwdata[EN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WINDOW:    prdata = APB_DATA_W'(r_cfg.window_size);
            REG_START_CNT: prdata = APB_DATA_W'(r_cfg.start_count);
            REG_START_AVG: prdata = APB_DATA_W'(r_cfg.start_average);
            REG_LOWER:     prdata = APB_DATA_W'(r_cfg.lower_threshold);
            REG_UPPER:     prdata = APB_DATA_W'(r_cfg.upper_threshold);
            REG_ENABLES:   prdata = APB_DATA_W'(r_cfg.alert_enables);
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/raa_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none

module raa_div #(
    parameter int DIVIDEND_W = 33,
    parameter int DIVISOR_W  = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic      [DIVIDEND_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [DIVISOR_W:0]    w_trial;
    logic [DIVISOR_W:0]    w_sub;
    logic                  w_ge;

    // dividend bits leave at the top of r_quo, quotient bits enter at the bottom
    assign w_trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_sub   = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == STEP_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/running_average_with_alerts_core.sv =====
// top level: running average sequencer, serial divider and register file
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  input    | i_in_valid / o_in_stall    | i_action, i_sample
//  result   | o_out_valid / i_out_stall  | o_average, o_sample_total, o_changed,
//           |                            |   o_below_lower, o_at_or_above_upper
//  config   | apb psel/penable/pready    | paddr, pwdata, prdata
//
// a sample beat occupies the block from prep through divide, sum and alert to emit, with the
// one-bit-per-cycle divider working through the DIF_W-bit difference in between
// a restart beat goes from idle straight to the emit state
// o_in_stall is high whenever the sequencer is not idle
// a held result waits in the output register; the next beat may be accepted meanwhile
// synchronous active-low reset clears state, counters and config to defaults
`default_nettype none

module running_average_with_alerts_core #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_action,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_sample,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [raa_pkg::AVG_W-1:0]        o_average,
    output logic        [raa_pkg::CNT_W-1:0]        o_sample_total,
    output logic                                    o_changed,
    output logic                                    o_below_lower,
    output logic                                    o_at_or_above_upper,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [raa_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [raa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [raa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);
    import raa_pkg::*;

    localparam int SCL_W = SAMPLE_BITS + FRACTION_BITS;
    localparam int DIF_W = ((SCL_W > AVG_W) ? SCL_W : AVG_W) + 1;
    localparam int NXT_W = DIF_W + 1;

    t_cfg   w_cfg;
    t_state r_state;
    t_state n_state;

    logic                     w_in_acc;
    logic                     w_room;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [DIF_W-1:0]         w_div_q;
    logic [DIF_W-1:0]         w_mag;
    logic signed [DIF_W-1:0]  w_scaled;
    logic [CNT_W-1:0]         w_win_ext;
    logic [WIN_W-1:0]         w_num;
    logic signed [AVG_W-1:0]  w_sat;
    logic signed [NXT_W-1:0]  w_next_max;
    logic signed [NXT_W-1:0]  w_next_min;
    logic                     w_chg;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [AVG_W-1:0]       r_avg;
    logic signed [AVG_W-1:0]       r_prev;
    logic [CNT_W-1:0]              r_count;
    logic [WIN_W-1:0]              r_num;
    logic signed [DIF_W-1:0]       r_diff;
    logic                          r_neg;
    logic signed [DIF_W-1:0]       r_quo_s;
    logic signed [NXT_W-1:0]       r_next;
    logic                          r_chg;
    logic                          r_low;
    logic                          r_up;

    logic                          r_out_valid;
    logic signed [AVG_W-1:0]       r_out_avg;
    logic [CNT_W-1:0]              r_out_cnt;
    logic                          r_out_chg;
    logic                          r_out_low;
    logic                          r_out_up;

    raa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    raa_div #(
        .DIVIDEND_W (DIF_W),
        .DIVISOR_W  (WIN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_num),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign w_room     = !r_out_valid || !i_out_stall;

    // sample placed on the fixed-point grid
    assign w_scaled  = DIF_W'(signed'({r_sample, {FRACTION_BITS{1'b0}}}));
    assign w_win_ext = CNT_W'(w_cfg.window_size);

    // divisor = min(count, window), never zero
    always_comb begin
        if (r_count > w_win_ext) begin
            w_num = w_cfg.window_size;
        end else begin
            w_num = r_count[WIN_W-1:0];
        end
        if (w_num == '0) begin
            w_num = WIN_W'(1);
        end
    end

    assign w_mag = r_neg ? DIF_W'(-r_diff) : DIF_W'(r_diff);

    assign w_next_max = NXT_W'(AVG_MAX);
    assign w_next_min = NXT_W'(AVG_MIN);

    always_comb begin
        if (r_next > w_next_max) begin
            w_sat = AVG_MAX;
        end else if (r_next < w_next_min) begin
            w_sat = AVG_MIN;
        end else begin
            w_sat = signed'(r_next[AVG_W-1:0]);
        end
    end

    assign w_chg = (w_sat != r_prev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_action ? ST_EMIT : ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_ALERT;
            end
            ST_ALERT: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_room) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg   <= '0;
            r_prev  <= '0;
            r_count <= '0;
        end else if (w_in_acc && i_action) begin
            r_avg   <= w_cfg.start_average;
            r_prev  <= w_cfg.start_average;
            r_count <= w_cfg.start_count;
        end else if (w_in_acc) begin
            if (r_count != '1) begin
                r_count <= r_count + CNT_W'(1);
            end
        end else if (r_state == ST_ALERT && w_chg) begin
            r_avg  <= w_sat;
            r_prev <= w_sat;
        end else if (r_state == ST_ALERT) begin
            r_avg <= w_sat;
        end
    end

    // per-beat working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_sample <= i_sample;
                r_chg    <= 1'b0;
                r_low    <= 1'b0;
                r_up     <= 1'b0;
            end
            ST_PREP: begin
                r_num  <= w_num;
                r_diff <= w_scaled - DIF_W'(r_avg);
                r_neg  <= w_scaled < DIF_W'(r_avg);
            end
            ST_DIV_WAIT: begin
                r_quo_s <= r_neg ? -signed'(w_div_q) : signed'(w_div_q);
            end
            ST_SUM: begin
                r_next <= NXT_W'(r_avg) + NXT_W'(r_quo_s);
            end
            ST_ALERT: begin
                // thresholds compare against the clamped average
                r_chg <= w_chg && w_cfg.alert_enables[EN_CHG];
                r_low <= w_chg && w_cfg.alert_enables[EN_LOW]
                         && (w_sat < w_cfg.lower_threshold);
                r_up  <= w_chg && w_cfg.alert_enables[EN_UP]
                         && (w_sat >= w_cfg.upper_threshold);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && w_room) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_room) begin
            r_out_avg <= r_avg;
            r_out_cnt <= r_count;
            r_out_chg <= r_chg;
            r_out_low <= r_low;
            r_out_up  <= r_up;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_average           = r_out_avg;
    assign o_sample_total      = r_out_cnt;
    assign o_changed           = r_out_chg;
    assign o_below_lower       = r_out_low;
    assign o_at_or_above_upper = r_out_up;

endmodule

`default_nettype wire
